// File: sv/cfa_enc_pkg.sv
`default_nettype none

package cfa_enc_pkg;

  // command codes of the input channel
  typedef enum logic [3:0] {
    CMD_START_REGION = 4'd0,
    CMD_END_REGION   = 4'd1,
    CMD_ADVANCE_LOC  = 4'd2,
    CMD_DEF_CFA      = 4'd3,
    CMD_CFA_REG      = 4'd4,
    CMD_CFA_OFF      = 4'd5,
    CMD_ADJUST_OFF   = 4'd6,
    CMD_SAME_VALUE   = 4'd7,
    CMD_OFFSET       = 4'd8,
    CMD_OFFSET_SF    = 4'd9,
    CMD_RESTORE      = 4'd10,
    CMD_NOP          = 4'd11
  } cmd_t;

  // how the operand tail of an instruction is coded
  typedef enum logic [1:0] {
    VK_NONE,
    VK_LE,
    VK_ULEB,
    VK_SLEB
  } val_kind_t;

  // serializer phase
  typedef enum logic [1:0] {
    PH_OP,
    PH_REG,
    PH_VAL
  } phase_t;

  // one classified instruction handed from front end to back end
  typedef struct packed {
    logic [7:0]  op;
    logic        has_reg;
    logic [7:0]  regn;
    val_kind_t   kind;
    logic [3:0]  le_count;
    logic [63:0] value;
  } job_t;

  // dwarf call-frame opcodes
  localparam logic [7:0] OP_SET_LOC     = 8'h01;
  localparam logic [7:0] OP_ADV_LOC1    = 8'h02;
  localparam logic [7:0] OP_ADV_LOC2    = 8'h03;
  localparam logic [7:0] OP_ADV_LOC4    = 8'h04;
  localparam logic [7:0] OP_OFFSET_EXT  = 8'h05;
  localparam logic [7:0] OP_RESTORE_EXT = 8'h06;
  localparam logic [7:0] OP_SAME_VALUE  = 8'h08;
  localparam logic [7:0] OP_DEF_CFA     = 8'h0c;
  localparam logic [7:0] OP_DEF_CFA_REG = 8'h0d;
  localparam logic [7:0] OP_DEF_CFA_OFF = 8'h0e;
  localparam logic [7:0] OP_OFFSET_SF   = 8'h11;
  localparam logic [7:0] OP_ADV_LOC     = 8'h40;
  localparam logic [7:0] OP_OFFSET      = 8'h80;
  localparam logic [7:0] OP_RESTORE     = 8'hc0;
  localparam logic [7:0] OP_NOP         = 8'h00;

  // default depth of the job queue
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

endpackage

`default_nettype wire

// File: sv/cfa_enc_in_if.sv
`default_nettype none

interface cfa_enc_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  command;
  logic [7:0]  reg_req;
  logic [63:0] operand;

  modport source (output valid, command, reg_req, operand, input ready);
  modport sink (input valid, command, reg_req, operand, output ready);
endinterface

`default_nettype wire

// File: sv/cfa_enc_out_if.sv
`default_nettype none

interface cfa_enc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink (input valid, out_byte, last, output ready);
endinterface

`default_nettype wire

// File: sv/cfa_instruction_encoder_top.sv
`default_nettype none

// channel   dir  handshake     payload
// cmd_in    in   valid/ready   command[3:0], reg_req[7:0], operand[63:0]
// byte_out  out  valid/ready   out_byte[7:0], last
//
// a request is taken whenever the job queue has room; commands that emit
// nothing only update state (region start/end) or are dropped (unknown codes).
// the byte serializer emits one byte per cycle while byte_out is not stalled;
// an encoding has 1 to 13 bytes, and back-to-back jobs follow without a gap.
// sync reset clears frame state, queue and output.
// a stalled byte_out holds its output register, the serializer stops, the
// queue fills to QDEPTH jobs and then cmd_in.ready drops.

module cfa_instruction_encoder_top #(
  parameter int unsigned QDEPTH = cfa_enc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  cfa_enc_in_if.sink     cmd_in,
  cfa_enc_out_if.source  byte_out
);

  cfa_enc_pkg::job_t front_job;
  logic              front_valid;
  logic              front_ready;
  cfa_enc_pkg::job_t back_job;
  logic              back_valid;
  logic              back_ready;

  // classify requests and track frame state
  cfa_enc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_in    (cmd_in),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  // decoupling queue
  cfa_enc_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // byte serializer
  cfa_enc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_ready (back_ready),
    .byte_out  (byte_out)
  );

endmodule

`default_nettype wire

// File: sv/cfa_enc_front.sv
`default_nettype none

module cfa_enc_front (
  input  wire logic          clk,
  input  wire logic          rst,
  cfa_enc_in_if.sink         cmd_in,
  output cfa_enc_pkg::job_t  job,
  output logic               job_valid,
  input  wire logic          job_ready
);

  logic [63:0] location;
  logic [63:0] location_next;
  logic        location_valid;
  logic        location_valid_next;
  logic [63:0] cfa_offset;
  logic [63:0] cfa_offset_next;
  logic [63:0] initial_cfa_offset;
  logic [63:0] initial_cfa_offset_next;
  logic        in_region;
  logic        in_region_next;

  logic        accept;
  logic        emits;
  logic [63:0] delta;
  logic [63:0] adj_sum;
  logic        reg_small;

  // every request waits for room in the job queue
  assign cmd_in.ready = job_ready;
  assign accept       = cmd_in.valid && job_ready;
  assign job_valid    = cmd_in.valid && emits;

  assign delta     = cmd_in.operand - location;
  assign adj_sum   = cfa_offset + cmd_in.operand;
  assign reg_small = (cmd_in.reg_req[7:6] == 2'b00);

  // classify the request and work out the tracked state
  always_comb begin
    job                     = '0;
    job.regn                = cmd_in.reg_req;
    job.value               = cmd_in.operand;
    job.kind                = cfa_enc_pkg::VK_NONE;
    emits                   = 1'b0;
    location_next           = location;
    location_valid_next     = location_valid;
    cfa_offset_next         = cfa_offset;
    initial_cfa_offset_next = initial_cfa_offset;
    in_region_next          = in_region;
    unique case (cfa_enc_pkg::cmd_t'(cmd_in.command))
      cfa_enc_pkg::CMD_START_REGION: begin
        in_region_next      = 1'b1;
        location_next       = cmd_in.operand;
        location_valid_next = 1'b1;
        cfa_offset_next     = initial_cfa_offset;
      end
      cfa_enc_pkg::CMD_END_REGION: begin
        in_region_next      = 1'b0;
        location_valid_next = 1'b0;
      end
      cfa_enc_pkg::CMD_ADVANCE_LOC: begin
        emits               = 1'b1;
        location_next       = cmd_in.operand;
        location_valid_next = 1'b1;
        job.kind            = cfa_enc_pkg::VK_LE;
        priority if (!location_valid) begin
          job.op       = cfa_enc_pkg::OP_SET_LOC;
          job.le_count = 4'd8;
        end else if (delta[63:6] == '0) begin
          job.op   = cfa_enc_pkg::OP_ADV_LOC | {2'b00, delta[5:0]};
          job.kind = cfa_enc_pkg::VK_NONE;
        end else if (delta[63:8] == '0) begin
          job.op       = cfa_enc_pkg::OP_ADV_LOC1;
          job.le_count = 4'd1;
          job.value    = delta;
        end else if (delta[63:16] == '0) begin
          job.op       = cfa_enc_pkg::OP_ADV_LOC2;
          job.le_count = 4'd2;
          job.value    = delta;
        end else if (delta[63:32] == '0) begin
          job.op       = cfa_enc_pkg::OP_ADV_LOC4;
          job.le_count = 4'd4;
          job.value    = delta;
        end else begin
          job.op       = cfa_enc_pkg::OP_SET_LOC;
          job.le_count = 4'd8;
        end
      end
      cfa_enc_pkg::CMD_DEF_CFA: begin
        emits           = 1'b1;
        job.op          = cfa_enc_pkg::OP_DEF_CFA;
        job.has_reg     = 1'b1;
        job.kind        = cfa_enc_pkg::VK_ULEB;
        cfa_offset_next = cmd_in.operand;
        if (!in_region) begin
          initial_cfa_offset_next = cmd_in.operand;
        end
      end
      cfa_enc_pkg::CMD_CFA_REG: begin
        emits       = 1'b1;
        job.op      = cfa_enc_pkg::OP_DEF_CFA_REG;
        job.has_reg = 1'b1;
      end
      cfa_enc_pkg::CMD_CFA_OFF: begin
        emits    = 1'b1;
        job.op   = cfa_enc_pkg::OP_DEF_CFA_OFF;
        job.kind = cfa_enc_pkg::VK_ULEB;
      end
      cfa_enc_pkg::CMD_ADJUST_OFF: begin
        emits           = 1'b1;
        job.op          = cfa_enc_pkg::OP_DEF_CFA_OFF;
        job.kind        = cfa_enc_pkg::VK_ULEB;
        job.value       = adj_sum;
        cfa_offset_next = adj_sum;
      end
      cfa_enc_pkg::CMD_SAME_VALUE: begin
        emits       = 1'b1;
        job.op      = cfa_enc_pkg::OP_SAME_VALUE;
        job.has_reg = 1'b1;
      end
      cfa_enc_pkg::CMD_OFFSET: begin
        emits    = 1'b1;
        job.kind = cfa_enc_pkg::VK_ULEB;
        if (reg_small) begin
          job.op = cfa_enc_pkg::OP_OFFSET | cmd_in.reg_req;
        end else begin
          job.op      = cfa_enc_pkg::OP_OFFSET_EXT;
          job.has_reg = 1'b1;
        end
      end
      cfa_enc_pkg::CMD_OFFSET_SF: begin
        emits       = 1'b1;
        job.op      = cfa_enc_pkg::OP_OFFSET_SF;
        job.has_reg = 1'b1;
        job.kind    = cfa_enc_pkg::VK_SLEB;
      end
      cfa_enc_pkg::CMD_RESTORE: begin
        emits = 1'b1;
        if (reg_small) begin
          job.op = cfa_enc_pkg::OP_RESTORE | cmd_in.reg_req;
        end else begin
          job.op      = cfa_enc_pkg::OP_RESTORE_EXT;
          job.has_reg = 1'b1;
        end
      end
      cfa_enc_pkg::CMD_NOP: begin
        emits  = 1'b1;
        job.op = cfa_enc_pkg::OP_NOP;
      end
      default: begin
        emits = 1'b0;
      end
    endcase
  end

  // tracked frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      location           <= '0;
      location_valid     <= 1'b0;
      cfa_offset         <= '0;
      initial_cfa_offset <= '0;
      in_region          <= 1'b0;
    end else if (accept) begin
      location           <= location_next;
      location_valid     <= location_valid_next;
      cfa_offset         <= cfa_offset_next;
      initial_cfa_offset <= initial_cfa_offset_next;
      in_region          <= in_region_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/cfa_enc_queue.sv
`default_nettype none

module cfa_enc_queue #(
  parameter int unsigned QDEPTH = cfa_enc_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfa_enc_pkg::job_t  push_data,
  input  wire logic               push_valid,
  output logic                    push_ready,
  output cfa_enc_pkg::job_t       pop_data,
  output logic                    pop_valid,
  input  wire logic               pop_ready
);

  localparam int unsigned PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QDEPTH + 1);

  cfa_enc_pkg::job_t  mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push_fire;
  logic               pop_fire;

  assign push_ready = (count != CNT_W'(QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  // fill count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("job queue overfilled");

endmodule

`default_nettype wire

// File: sv/cfa_enc_back.sv
`default_nettype none

module cfa_enc_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfa_enc_pkg::job_t  job,
  input  wire logic               job_valid,
  output logic                    job_ready,
  cfa_enc_out_if.source           byte_out
);

  cfa_enc_pkg::phase_t    phase;
  cfa_enc_pkg::phase_t    phase_next;
  logic                   busy;
  logic [7:0]             op;
  logic                   has_reg;
  logic [7:0]             regv;
  cfa_enc_pkg::val_kind_t kind;
  logic [3:0]             cnt;
  logic [63:0]            val;

  logic                   out_valid;
  logic [7:0]             out_byte_r;
  logic                   out_last_r;

  logic                   emit_go;
  logic                   load;
  logic [7:0]             byte_val;
  logic                   byte_last;
  logic                   reg_more;
  logic [63:0]            uleb_rest;
  logic [63:0]            sleb_rest;
  logic                   uleb_more;
  logic                   sleb_more;

  assign emit_go   = busy && (!out_valid || byte_out.ready);
  assign job_ready = !busy || (emit_go && byte_last);
  assign load      = job_valid && job_ready;

  assign byte_out.valid    = out_valid;
  assign byte_out.out_byte = out_byte_r;
  assign byte_out.last     = out_last_r;

  // leb128 digit continuation
  assign reg_more  = regv[7];
  assign uleb_rest = {7'b0, val[63:7]};
  assign sleb_rest = {{7{val[63]}}, val[63:7]};
  assign uleb_more = (uleb_rest != '0);
  assign sleb_more = !((sleb_rest == '0) && !val[6]) && !((sleb_rest == '1) && val[6]);

  // byte and last flag for the current phase
  always_comb begin
    byte_val  = op;
    byte_last = 1'b1;
    unique case (phase)
      cfa_enc_pkg::PH_OP: begin
        byte_val  = op;
        byte_last = !has_reg && (kind == cfa_enc_pkg::VK_NONE);
      end
      cfa_enc_pkg::PH_REG: begin
        byte_val  = {reg_more, regv[6:0]};
        byte_last = !reg_more && (kind == cfa_enc_pkg::VK_NONE);
      end
      cfa_enc_pkg::PH_VAL: begin
        unique case (kind)
          cfa_enc_pkg::VK_LE: begin
            byte_val  = val[7:0];
            byte_last = (cnt == 4'd1);
          end
          cfa_enc_pkg::VK_ULEB: begin
            byte_val  = {uleb_more, val[6:0]};
            byte_last = !uleb_more;
          end
          cfa_enc_pkg::VK_SLEB: begin
            byte_val  = {sleb_more, val[6:0]};
            byte_last = !sleb_more;
          end
          cfa_enc_pkg::VK_NONE: begin
            byte_val  = val[7:0];
            byte_last = 1'b1;
          end
        endcase
      end
      default: begin
        byte_val  = op;
        byte_last = 1'b1;
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    priority if (load) begin
      phase_next = cfa_enc_pkg::PH_OP;
    end else if (emit_go) begin
      if (byte_last) begin
        phase_next = cfa_enc_pkg::PH_OP;
      end else begin
        unique case (phase)
          cfa_enc_pkg::PH_OP:  phase_next = has_reg ? cfa_enc_pkg::PH_REG : cfa_enc_pkg::PH_VAL;
          cfa_enc_pkg::PH_REG: phase_next = reg_more ? cfa_enc_pkg::PH_REG : cfa_enc_pkg::PH_VAL;
          cfa_enc_pkg::PH_VAL: phase_next = cfa_enc_pkg::PH_VAL;
          default:             phase_next = cfa_enc_pkg::PH_OP;
        endcase
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= cfa_enc_pkg::PH_OP;
      busy      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (load) begin
        busy <= 1'b1;
      end else if (emit_go && byte_last) begin
        busy <= 1'b0;
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (byte_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // job datapath and output register
  always_ff @(posedge clk) begin
    if (emit_go) begin
      out_byte_r <= byte_val;
      out_last_r <= byte_last;
    end
    if (load) begin
      op      <= job.op;
      has_reg <= job.has_reg;
      regv    <= job.regn;
      kind    <= job.kind;
      cnt     <= job.le_count;
      val     <= job.value;
    end else if (emit_go) begin
      unique case (phase)
        cfa_enc_pkg::PH_REG: regv <= {7'b0, regv[7]};
        cfa_enc_pkg::PH_VAL: begin
          unique case (kind)
            cfa_enc_pkg::VK_LE: begin
              val <= {8'b0, val[63:8]};
              cnt <= cnt - 1'b1;
            end
            cfa_enc_pkg::VK_ULEB: val <= uleb_rest;
            cfa_enc_pkg::VK_SLEB: val <= sleb_rest;
            cfa_enc_pkg::VK_NONE: val <= val;
          endcase
        end
        default: regv <= regv;
      endcase
    end
  end

  // an idle serializer always waits at the opcode phase
  a_idle_phase: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (phase == cfa_enc_pkg::PH_OP))
    else $error("serializer idle outside opcode phase");

  // register digits only for jobs that carry a register
  a_reg_phase: assert property (@(posedge clk) disable iff (rst)
    (busy && (phase == cfa_enc_pkg::PH_REG)) |-> has_reg)
    else $error("register phase without register operand");

  // fixed-width fields never run out of bytes before the last one
  a_le_count: assert property (@(posedge clk) disable iff (rst)
    (busy && (phase == cfa_enc_pkg::PH_VAL) && (kind == cfa_enc_pkg::VK_LE)) |-> (cnt != 4'd0))
    else $error("little-endian byte count underflow");

  // a loaded job starts with its opcode byte
  a_load_op: assert property (@(posedge clk) disable iff (rst)
    load |=> (busy && (phase == cfa_enc_pkg::PH_OP)))
    else $error("job load did not restart at opcode");

endmodule

`default_nettype wire

// File: bench/cfa_instruction_encoder_top_tb.sv
`timescale 1ns / 100ps

module cfa_instruction_encoder_top_tb;

  localparam int unsigned MAX_BYTES     = 13;
  localparam logic [3:0]  CMD_UNUSED_LO = 4'd12;
  localparam logic [3:0]  CMD_UNUSED_HI = 4'd15;
  localparam logic [63:0] SMALL_MAX     = 64'h3f;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned RUN_LIMIT_NS  = 5_000_000;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } enc_byte_t;

  logic clk;
  logic rst;

  cfa_enc_in_if  cmd_in ();
  cfa_enc_out_if byte_out ();

  cfa_instruction_encoder_top dut (
    .clk      (clk),
    .rst      (rst),
    .cmd_in   (cmd_in),
    .byte_out (byte_out)
  );

  // frame state as the block should hold it
  logic [63:0] cur_loc;
  logic        loc_known;
  logic [63:0] cur_cfa_off;
  logic [63:0] cie_cfa_off;
  logic        in_fde;

  logic [7:0]  enc_buf[$];
  enc_byte_t   expected_bytes[$];
  int unsigned error_cnt;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  bit          hold_go;
  bit          hold_done;
  int unsigned hold_count;

  // clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // byte encoders
  function automatic void put_le(logic [63:0] v, int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      enc_buf.push_back(v[7:0]);
      v = v >> 8;
    end
  endfunction

  function automatic void put_uleb(logic [63:0] v);
    logic [7:0] b;
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0) b[7] = 1'b1;
      enc_buf.push_back(b);
    end while (v != 64'd0);
  endfunction

  function automatic void put_sleb(logic [63:0] v);
    logic [7:0] b;
    logic       neg;
    logic       more;
    do begin
      b = {1'b0, v[6:0]};
      neg = v[63];
      v = v >> 7;
      if (neg) v[63:57] = 7'h7f;
      more = !(v == 64'd0 && !b[6]) && !(v == '1 && b[6]);
      if (more) b[7] = 1'b1;
      enc_buf.push_back(b);
    end while (more);
  endfunction

  // bytes one command should produce, with frame state update
  function automatic void predict_cmd(logic [3:0] cmd, logic [7:0] regn, logic [63:0] opnd);
    logic [63:0] delta;
    int unsigned n;
    enc_buf.delete();
    delta = opnd - cur_loc;
    case (cmd)
      cfa_enc_pkg::CMD_START_REGION: begin
        in_fde = 1'b1;
        cur_loc = opnd;
        loc_known = 1'b1;
        cur_cfa_off = cie_cfa_off;
      end
      cfa_enc_pkg::CMD_END_REGION: begin
        in_fde = 1'b0;
        loc_known = 1'b0;
      end
      cfa_enc_pkg::CMD_ADVANCE_LOC: begin
        if (!loc_known || delta > 64'hffff_ffff) begin
          enc_buf.push_back(cfa_enc_pkg::OP_SET_LOC);
          put_le(opnd, 8);
        end else if (delta <= SMALL_MAX) begin
          enc_buf.push_back(cfa_enc_pkg::OP_ADV_LOC | delta[7:0]);
        end else if (delta <= 64'hff) begin
          enc_buf.push_back(cfa_enc_pkg::OP_ADV_LOC1);
          put_le(delta, 1);
        end else if (delta <= 64'hffff) begin
          enc_buf.push_back(cfa_enc_pkg::OP_ADV_LOC2);
          put_le(delta, 2);
        end else begin
          enc_buf.push_back(cfa_enc_pkg::OP_ADV_LOC4);
          put_le(delta, 4);
        end
        cur_loc = opnd;
        loc_known = 1'b1;
      end
      cfa_enc_pkg::CMD_DEF_CFA: begin
        enc_buf.push_back(cfa_enc_pkg::OP_DEF_CFA);
        put_uleb({56'd0, regn});
        put_uleb(opnd);
        if (!in_fde) cie_cfa_off = opnd;
        cur_cfa_off = opnd;
      end
      cfa_enc_pkg::CMD_CFA_REG: begin
        enc_buf.push_back(cfa_enc_pkg::OP_DEF_CFA_REG);
        put_uleb({56'd0, regn});
      end
      cfa_enc_pkg::CMD_CFA_OFF: begin
        enc_buf.push_back(cfa_enc_pkg::OP_DEF_CFA_OFF);
        put_uleb(opnd);
      end
      cfa_enc_pkg::CMD_ADJUST_OFF: begin
        cur_cfa_off = cur_cfa_off + opnd;
        enc_buf.push_back(cfa_enc_pkg::OP_DEF_CFA_OFF);
        put_uleb(cur_cfa_off);
      end
      cfa_enc_pkg::CMD_SAME_VALUE: begin
        enc_buf.push_back(cfa_enc_pkg::OP_SAME_VALUE);
        put_uleb({56'd0, regn});
      end
      cfa_enc_pkg::CMD_OFFSET: begin
        if ({56'd0, regn} <= SMALL_MAX) begin
          enc_buf.push_back(cfa_enc_pkg::OP_OFFSET | regn);
        end else begin
          enc_buf.push_back(cfa_enc_pkg::OP_OFFSET_EXT);
          put_uleb({56'd0, regn});
        end
        put_uleb(opnd);
      end
      cfa_enc_pkg::CMD_OFFSET_SF: begin
        enc_buf.push_back(cfa_enc_pkg::OP_OFFSET_SF);
        put_uleb({56'd0, regn});
        put_sleb(opnd);
      end
      cfa_enc_pkg::CMD_RESTORE: begin
        if ({56'd0, regn} <= SMALL_MAX) begin
          enc_buf.push_back(cfa_enc_pkg::OP_RESTORE | regn);
        end else begin
          enc_buf.push_back(cfa_enc_pkg::OP_RESTORE_EXT);
          put_uleb({56'd0, regn});
        end
      end
      cfa_enc_pkg::CMD_NOP: enc_buf.push_back(cfa_enc_pkg::OP_NOP);
      default: ;
    endcase
    n = (enc_buf.size() > MAX_BYTES) ? MAX_BYTES : enc_buf.size();
    for (int unsigned i = 0; i < n; i++)
      expected_bytes.push_back('{out_byte: enc_buf[i], last: (i == n - 1)});
  endfunction

  // offer one request, hold it until taken
  task automatic send_cmd(logic [3:0] cmd, logic [7:0] regn, logic [63:0] opnd);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_in.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_in.valid   <= 1'b1;
    cmd_in.command <= cmd;
    cmd_in.reg_req <= regn;
    cmd_in.operand <= opnd;
    do @(posedge clk); while (!cmd_in.ready);
    predict_cmd(cmd, regn, opnd);
  endtask

  // stop offering and let every pending byte come out
  task automatic wait_drained();
    cmd_in.valid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random operands of varied length
  function automatic logic [63:0] rand_wide();
    logic [63:0] v;
    int unsigned len;
    v = {$urandom, $urandom};
    len = $urandom_range(64);
    if (len < 64) v = v & ((64'd1 << len) - 64'd1);
    return v;
  endfunction

  function automatic logic [63:0] rand_signed();
    logic [63:0] v;
    v = rand_wide();
    if ($urandom_range(1) == 0) v = 64'd0 - v;
    return v;
  endfunction

  function automatic logic [7:0] rand_reg();
    if ($urandom_range(3) == 0) return 8'($urandom);
    return 8'($urandom_range(63));
  endfunction

  function automatic logic [63:0] rand_delta();
    case ($urandom_range(5))
      0: return 64'($urandom_range(63));
      1: return 64'($urandom_range(255, 64));
      2: return 64'($urandom_range(65535, 256));
      3: return 64'($urandom_range(32'hffff_ffff, 65536));
      4: return rand_wide();
      default: return 64'd0 - 64'($urandom_range(1000, 1));
    endcase
  endfunction

  // one command of a frame body, advances weighted up
  task automatic send_body_cmd();
    logic [3:0]  cmd;
    logic [63:0] opnd;
    if ($urandom_range(2) == 0) cmd = cfa_enc_pkg::CMD_ADVANCE_LOC;
    else cmd = 4'($urandom_range(cfa_enc_pkg::CMD_NOP, cfa_enc_pkg::CMD_DEF_CFA));
    case (cmd)
      cfa_enc_pkg::CMD_ADVANCE_LOC: opnd = cur_loc + rand_delta();
      cfa_enc_pkg::CMD_ADJUST_OFF, cfa_enc_pkg::CMD_OFFSET_SF: opnd = rand_signed();
      default: opnd = rand_wide();
    endcase
    send_cmd(cmd, rand_reg(), opnd);
  endtask

  // advance forms, region bookkeeping, cfa offset tracking
  task automatic test_frame_tracking();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cmd(cfa_enc_pkg::CMD_DEF_CFA, 8'd7, 64'd16);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h0000_7fff_1234_5678);
    send_cmd(cfa_enc_pkg::CMD_START_REGION, 8'd0, 64'h1000);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h1000);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h103f);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h107f);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h117f);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h1_117f);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h1_0001_117f);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, 64'h1_0001_117e);
    send_cmd(cfa_enc_pkg::CMD_CFA_OFF, 8'd0, 64'd100);
    send_cmd(cfa_enc_pkg::CMD_ADJUST_OFF, 8'd0, 64'd0 - 64'd24);
    send_cmd(cfa_enc_pkg::CMD_END_REGION, 8'd0, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_ADVANCE_LOC, 8'd0, '1);
    wait_drained();
  endtask

  // packed and extended forms, leb extremes, ignored codes
  task automatic test_encoding_forms();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_cmd(cfa_enc_pkg::CMD_NOP, 8'd0, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_SAME_VALUE, 8'd255, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_CFA_REG, 8'd128, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_CFA_OFF, 8'd0, '1);
    send_cmd(cfa_enc_pkg::CMD_RESTORE, 8'd63, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_RESTORE, 8'd64, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_OFFSET, 8'd63, 64'd0);
    send_cmd(cfa_enc_pkg::CMD_OFFSET, 8'd255, '1);
    send_cmd(cfa_enc_pkg::CMD_OFFSET_SF, 8'd200, 64'h8000_0000_0000_0000);
    send_cmd(cfa_enc_pkg::CMD_OFFSET_SF, 8'd0, 64'd0 - 64'd65);
    send_cmd(cfa_enc_pkg::CMD_OFFSET_SF, 8'd1, 64'd64);
    send_cmd(CMD_UNUSED_HI, 8'd255, '1);
    send_cmd(cfa_enc_pkg::CMD_DEF_CFA, 8'd255, '1);
    wait_drained();
  endtask

  // output held off for a long stretch while requests keep coming
  task automatic test_output_hold();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_go = 1'b1;
    send_cmd(cfa_enc_pkg::CMD_START_REGION, 8'd0, rand_wide());
    repeat (12) send_body_cmd();
    cmd_in.valid <= 1'b0;
    do @(posedge clk); while (!hold_done);
    hold_go = 1'b0;
    wait_drained();
  endtask

  // mostly well-formed frames with random content, some noise
  task automatic test_random_frames(int unsigned item_goal, int unsigned idle_pct,
                                    int unsigned stall_pct);
    int unsigned sent;
    int unsigned body_len;
    logic [3:0]  cmd;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(9) == 0) begin
        // any code at all, unknown ones included
        cmd = 4'($urandom);
        send_cmd(cmd, 8'($urandom), rand_wide());
        if (cmd < CMD_UNUSED_LO) sent++;
      end else begin
        if (!in_fde && $urandom_range(2) == 0) begin
          send_cmd(cfa_enc_pkg::CMD_DEF_CFA, rand_reg(), rand_wide());
          sent++;
        end
        if (!in_fde || $urandom_range(3) == 0) begin
          send_cmd(cfa_enc_pkg::CMD_START_REGION, 8'($urandom), rand_wide());
          sent++;
        end
        body_len = $urandom_range(8, 1);
        repeat (body_len) send_body_cmd();
        sent += body_len;
        if ($urandom_range(3) != 0) begin
          send_cmd(cfa_enc_pkg::CMD_END_REGION, 8'($urandom), rand_wide());
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  // result sink with random stalls and a counted hold-off
  always @(posedge clk) begin
    if (hold_go && !hold_done) begin
      byte_out.ready <= 1'b0;
      hold_count <= hold_count + 1;
      if (hold_count + 1 >= HOLD_CYCLES) hold_done <= 1'b1;
    end else begin
      if (!hold_go) begin
        hold_done <= 1'b0;
        hold_count <= 0;
      end
      byte_out.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each byte against the oldest expectation
  always @(posedge clk) begin : byte_check
    enc_byte_t exp_b;
    if (!rst && byte_out.valid && byte_out.ready) begin
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: out_byte %h last %b", byte_out.out_byte, byte_out.last);
        error_cnt++;
      end else begin
        exp_b = expected_bytes.pop_front();
        if (byte_out.out_byte !== exp_b.out_byte) begin
          $error("out_byte: expected %h, actual %h", exp_b.out_byte, byte_out.out_byte);
          error_cnt++;
        end
        if (byte_out.last !== exp_b.last) begin
          $error("last: expected %b, actual %b", exp_b.last, byte_out.last);
          error_cnt++;
        end
      end
    end
  end

  // test sequence
  initial begin
    rst            <= 1'b1;
    cmd_in.valid   <= 1'b0;
    cmd_in.command <= cfa_enc_pkg::CMD_NOP;
    cmd_in.reg_req <= 8'd0;
    cmd_in.operand <= 64'd0;
    cur_loc     = 64'd0;
    loc_known   = 1'b0;
    cur_cfa_off = 64'd0;
    cie_cfa_off = 64'd0;
    in_fde      = 1'b0;
    error_cnt      = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_frame_tracking();
    test_encoding_forms();
    test_output_hold();
    test_random_frames(40, 0, 0);
    test_random_frames(40, 47, 0);
    test_random_frames(40, 0, 47);
    test_random_frames(40, 11, 11);

    if (expected_bytes.size() != 0) begin
      $error("bytes still expected at end: %0d", expected_bytes.size());
      error_cnt++;
    end
    if (error_cnt == 0) begin
      $display("cfa_instruction_encoder_top_tb: done, clean");
    end else begin
      $display("cfa_instruction_encoder_top_tb: done, errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("cfa_instruction_encoder_top_tb: done, errors");
    $finish;
  end

endmodule

// File: cfa_instruction_encoder_top.f
sv/cfa_enc_pkg.sv
sv/cfa_enc_in_if.sv
sv/cfa_enc_out_if.sv
sv/cfa_enc_front.sv
sv/cfa_enc_queue.sv
sv/cfa_enc_back.sv
sv/cfa_instruction_encoder_top.sv
bench/cfa_instruction_encoder_top_tb.sv
